[hw/rtl/xeu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_pkg
// Shared types, character codes and the named-entity table for the XML
// entity decoder.
// ----------------------------------------------------------------------------
package xeu_pkg;

   localparam int HOLD_DEPTH_DEF     = 5;
   localparam int MAX_DEC_DIGITS_DEF = 3;

   localparam int NAME_COUNT  = 5;
   localparam int VALUE_W     = 10;
   localparam int DIGIT_W     = 2;

   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_X    = 8'h78;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_end;
   } rsp_payload_type;

   typedef enum logic [6:0] {
      M_IDLE = 7'b0000001,
      M_AMP  = 7'b0000010,
      M_NAME = 7'b0000100,
      M_HASH = 7'b0001000,
      M_DEC  = 7'b0010000,
      M_HEXX = 7'b0100000,
      M_HEXD = 7'b1000000
   } parse_mode_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_REPLAY = 3'b010,
      S_MID    = 3'b100
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic load_rep;
      logic load_mid;
   } ctrl_cmd_type;

   typedef struct packed {
      logic acc_rep;
      logic acc_mid;
      logic rep_last;
      logic mid_pend;
   } dp_status_type;

   // Named entities: quot, amp, apos, lt, gt
   function automatic logic [2:0] name_len(input logic [2:0] idx);
      case (idx)
         3'd0:    name_len = 3'd4;
         3'd1:    name_len = 3'd3;
         3'd2:    name_len = 3'd4;
         3'd3:    name_len = 3'd2;
         3'd4:    name_len = 3'd2;
         default: name_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] name_value(input logic [2:0] idx);
      case (idx)
         3'd0:    name_value = 8'h22;
         3'd1:    name_value = 8'h26;
         3'd2:    name_value = 8'h27;
         3'd3:    name_value = 8'h3C;
         3'd4:    name_value = 8'h3E;
         default: name_value = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [2:0] pos);
      case ({idx, pos})
         {3'd0, 3'd0}: name_char = 8'h71; // q
         {3'd0, 3'd1}: name_char = 8'h75; // u
         {3'd0, 3'd2}: name_char = 8'h6F; // o
         {3'd0, 3'd3}: name_char = 8'h74; // t
         {3'd1, 3'd0}: name_char = 8'h61; // a
         {3'd1, 3'd1}: name_char = 8'h6D; // m
         {3'd1, 3'd2}: name_char = 8'h70; // p
         {3'd2, 3'd0}: name_char = 8'h61; // a
         {3'd2, 3'd1}: name_char = 8'h70; // p
         {3'd2, 3'd2}: name_char = 8'h6F; // o
         {3'd2, 3'd3}: name_char = 8'h73; // s
         {3'd3, 3'd0}: name_char = 8'h6C; // l
         {3'd3, 3'd1}: name_char = 8'h74; // t
         {3'd4, 3'd0}: name_char = 8'h67; // g
         {3'd4, 3'd1}: name_char = 8'h74; // t
         default:      name_char = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

[hw/rtl/xeu_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_ctrl
// Sequencer: takes one request, then issues one output transaction per cycle
// unless stalled, from the held-byte replay and the pending single byte.
// ----------------------------------------------------------------------------
module xeu_ctrl
   import xeu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output ctrl_cmd_type       cmd,
   input  wire dp_status_type status
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           load_ok;

   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.acc_rep) begin
                  state_in = S_REPLAY;
               end else if (status.acc_mid) begin
                  state_in = S_MID;
               end
            end
         end
         S_REPLAY: begin
            if (load_ok) begin
               cmd.load_rep = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.rep_last) begin
                  state_in = status.mid_pend ? S_MID : S_IDLE;
               end
            end
         end
         S_MID: begin
            if (load_ok) begin
               cmd.load_mid = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/xeu_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_datapath
// Entity parser state, held-byte buffer, replay counter and the output
// register.
// ----------------------------------------------------------------------------
module xeu_datapath
   import xeu_pkg::*;
#(
   parameter int HOLD_DEPTH     = HOLD_DEPTH_DEF,
   parameter int MAX_DEC_DIGITS = MAX_DEC_DIGITS_DEF
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_data,
   input  wire ctrl_cmd_type    cmd,
   output dp_status_type        status,
   output rsp_payload_type      rsp_data
);

   localparam int CW = $clog2(HOLD_DEPTH + 1);
   localparam int IW = $clog2(HOLD_DEPTH);

   parse_mode_type              mode_ff, mode_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [VALUE_W-1:0]          value_ff, value_in;
   logic [DIGIT_W-1:0]          digits_ff, digits_in;
   logic [NAME_COUNT-1:0]       mask_ff, mask_in;
   logic [7:0]                  held_ff [HOLD_DEPTH];
   logic [CW-1:0]               rep_cnt_ff, rep_cnt_in;
   logic [IW-1:0]               rep_idx_ff, rep_idx_in;
   logic [7:0]                  mid_ff, mid_in;
   logic                        mid_pend_ff, mid_pend_in;
   logic                        end_pend_ff, end_pend_in;
   rsp_payload_type             rsp_data_ff, rsp_data_in;

   logic [7:0]                  c;
   logic                        active;
   logic [2:0]                  k;
   logic                        is_dig;
   logic                        is_hex;
   logic [3:0]                  hex_v;
   logic [NAME_COUNT-1:0]       next_mask;
   logic [NAME_COUNT-1:0]       full_mask;
   logic [7:0]                  full_value;
   logic                        push_req, emit_req, over_req, ok;
   parse_mode_type              p_mode;
   logic [VALUE_W-1:0]          p_value;
   logic [DIGIT_W-1:0]          p_digits;
   logic [NAME_COUNT-1:0]       p_mask;
   logic [7:0]                  emit_byte;
   parse_mode_type              r_mode;
   logic [CW-1:0]               r_cnt, r_rep;
   logic [VALUE_W-1:0]          r_value;
   logic [DIGIT_W-1:0]          r_digits;
   logic [NAME_COUNT-1:0]       r_mask;
   logic                        r_mid_v;
   logic [7:0]                  r_mid_b;
   logic                        r_wr;
   logic [IW-1:0]               r_wr_idx;
   logic [7:0]                  r_wr_data;
   logic                        rep_last;

   assign c      = req_data.in_byte;
   assign active = (mode_ff != M_IDLE) && (cnt_ff != '0);
   assign k      = 3'(cnt_ff - CW'(1));
   assign is_dig = (c >= 8'h30) && (c <= 8'h39);

   always_comb begin
      is_hex = 1'b1;
      hex_v  = 4'd0;
      if (is_dig) begin
         hex_v = 4'(c - 8'h30);
      end else if ((c >= 8'h61) && (c <= 8'h66)) begin
         hex_v = 4'(c - 8'h57);
      end else if ((c >= 8'h41) && (c <= 8'h46)) begin
         hex_v = 4'(c - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   always_comb begin
      full_value = 8'h00;
      for (int i = 0; i < NAME_COUNT; i++) begin
         next_mask[i] = mask_ff[i] && (name_len(3'(i)) > k) && (name_char(3'(i), k) == c);
         full_mask[i] = mask_ff[i] && (name_len(3'(i)) == k);
         if (full_mask[i]) begin
            full_value = name_value(3'(i));
         end
      end
   end

   // Extend or close the open entity
   always_comb begin
      push_req  = 1'b0;
      emit_req  = 1'b0;
      over_req  = 1'b0;
      emit_byte = 8'h00;
      p_mode    = mode_ff;
      p_value   = value_ff;
      p_digits  = digits_ff;
      p_mask    = mask_ff;
      case (mode_ff)
         M_AMP: begin
            if (c == CHAR_HASH) begin
               p_mode   = M_HASH;
               push_req = 1'b1;
            end else if (|next_mask) begin
               p_mode   = M_NAME;
               p_mask   = next_mask;
               push_req = 1'b1;
            end
         end
         M_NAME: begin
            if (c == CHAR_SEMI) begin
               if (|full_mask) begin
                  emit_req  = 1'b1;
                  emit_byte = full_value;
               end
            end else if (|next_mask) begin
               p_mask   = next_mask;
               push_req = 1'b1;
            end
         end
         M_HASH: begin
            if (is_dig) begin
               p_mode   = M_DEC;
               p_value  = VALUE_W'(hex_v);
               p_digits = DIGIT_W'(1);
               push_req = 1'b1;
            end else if (c == CHAR_X) begin
               p_mode   = M_HEXX;
               push_req = 1'b1;
            end
         end
         M_DEC: begin
            if (is_dig && (digits_ff < DIGIT_W'(MAX_DEC_DIGITS))) begin
               p_value  = (value_ff << 3) + (value_ff << 1) + VALUE_W'(hex_v);
               p_digits = digits_ff + DIGIT_W'(1);
               push_req = 1'b1;
            end else if (c == CHAR_SEMI) begin
               if (value_ff[VALUE_W-1:8] == '0) begin
                  emit_req  = 1'b1;
                  emit_byte = value_ff[7:0];
               end else begin
                  over_req = 1'b1;
               end
            end
         end
         M_HEXX: begin
            if (is_hex) begin
               p_mode   = M_HEXD;
               p_value  = VALUE_W'(hex_v);
               p_digits = DIGIT_W'(1);
               push_req = 1'b1;
            end
         end
         M_HEXD: begin
            if (is_hex && (digits_ff < DIGIT_W'(2))) begin
               p_value  = (value_ff << 4) + VALUE_W'(hex_v);
               p_digits = digits_ff + DIGIT_W'(1);
               push_req = 1'b1;
            end else if (c == CHAR_SEMI) begin
               emit_req  = 1'b1;
               emit_byte = value_ff[7:0];
            end
         end
         default: begin
         end
      endcase
      ok = active &&
           (emit_req || over_req || (push_req && (cnt_ff < CW'(HOLD_DEPTH))));
   end

   // Resolve the transaction into a replay length, a single byte and the new state
   always_comb begin
      r_mode    = mode_ff;
      r_cnt     = cnt_ff;
      r_value   = value_ff;
      r_digits  = digits_ff;
      r_mask    = mask_ff;
      r_rep     = '0;
      r_mid_v   = 1'b0;
      r_mid_b   = c;
      r_wr      = 1'b0;
      r_wr_idx  = cnt_ff[IW-1:0];
      r_wr_data = c;
      if (ok && push_req) begin
         r_mode   = p_mode;
         r_cnt    = cnt_ff + CW'(1);
         r_value  = p_value;
         r_digits = p_digits;
         r_mask   = p_mask;
         r_wr     = 1'b1;
      end else begin
         r_mode   = M_IDLE;
         r_cnt    = '0;
         r_value  = '0;
         r_digits = '0;
         if (ok && emit_req) begin
            r_mid_v = 1'b1;
            r_mid_b = emit_byte;
         end else if (ok && over_req) begin
            r_rep   = cnt_ff;
            r_mid_v = 1'b1;
            r_mid_b = CHAR_SEMI;
         end else begin
            r_rep = active ? cnt_ff : '0;
            if (c == CHAR_AMP) begin
               r_mode    = M_AMP;
               r_cnt     = CW'(1);
               r_mask    = '1;
               r_wr      = 1'b1;
               r_wr_idx  = '0;
               r_wr_data = CHAR_AMP;
            end else begin
               r_mid_v = 1'b1;
            end
         end
      end
      if (req_data.in_end && (r_cnt != '0)) begin
         if (r_rep == '0) begin
            r_rep = r_cnt;
         end else begin
            r_mid_v = 1'b1;
            r_mid_b = CHAR_AMP;
         end
         r_mode   = M_IDLE;
         r_cnt    = '0;
         r_value  = '0;
         r_digits = '0;
      end
   end

   assign rep_last = (CW'(rep_idx_ff) == (rep_cnt_ff - CW'(1)));

   always_comb begin
      mode_in     = mode_ff;
      cnt_in      = cnt_ff;
      value_in    = value_ff;
      digits_in   = digits_ff;
      mask_in     = mask_ff;
      rep_cnt_in  = rep_cnt_ff;
      rep_idx_in  = rep_idx_ff;
      mid_in      = mid_ff;
      mid_pend_in = mid_pend_ff;
      end_pend_in = end_pend_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.accept) begin
         mode_in     = r_mode;
         cnt_in      = r_cnt;
         value_in    = r_value;
         digits_in   = r_digits;
         mask_in     = r_mask;
         rep_cnt_in  = r_rep;
         rep_idx_in  = '0;
         mid_in      = r_mid_b;
         mid_pend_in = r_mid_v;
         end_pend_in = req_data.in_end;
      end
      if (cmd.load_rep) begin
         rsp_data_in.out_byte = held_ff[rep_idx_ff];
         rsp_data_in.out_end  = rep_last && !mid_pend_ff && end_pend_ff;
         rep_idx_in           = rep_idx_ff + IW'(1);
      end
      if (cmd.load_mid) begin
         rsp_data_in.out_byte = mid_ff;
         rsp_data_in.out_end  = end_pend_ff;
         mid_pend_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         cnt_ff      <= '0;
         value_ff    <= '0;
         digits_ff   <= '0;
         mask_ff     <= '1;
         mid_pend_ff <= 1'b0;
         end_pend_ff <= 1'b0;
         rep_cnt_ff  <= '0;
         rep_idx_ff  <= '0;
      end else begin
         mode_ff     <= mode_in;
         cnt_ff      <= cnt_in;
         value_ff    <= value_in;
         digits_ff   <= digits_in;
         mask_ff     <= mask_in;
         mid_pend_ff <= mid_pend_in;
         end_pend_ff <= end_pend_in;
         rep_cnt_ff  <= rep_cnt_in;
         rep_idx_ff  <= rep_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff      <= mid_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.accept && r_wr) begin
         held_ff[r_wr_idx] <= r_wr_data;
      end
   end

   assign status.acc_rep  = (r_rep != '0);
   assign status.acc_mid  = r_mid_v;
   assign status.rep_last = rep_last;
   assign status.mid_pend = mid_pend_ff;
   assign rsp_data        = rsp_data_ff;

endmodule
`default_nettype wire

[hw/rtl/xml_entity_unescape.sv]
`default_nettype none
// A taken request is registered in the sequencer state; its first result is then
// loaded into the output register. Each request gives 0 to 6 results; the single
// output register, fed one byte per cycle from the held-byte buffer unless the
// output stalls, sets the pace; a new request waits until the last result is loaded.
// Reset: synchronous, clears parse state and sequencer; held bytes are not cleared.
// ----------------------------------------------------------------------------
// xml_entity_unescape
// XML character entity decoder: named, decimal and hex entities become one
// byte; unmatched text is copied verbatim.
// ----------------------------------------------------------------------------
module xml_entity_unescape
   import xeu_pkg::*;
#(
   parameter int HOLD_DEPTH     = HOLD_DEPTH_DEF,
   parameter int MAX_DEC_DIGITS = MAX_DEC_DIGITS_DEF
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   xeu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   xeu_datapath #(
      .HOLD_DEPTH     (HOLD_DEPTH),
      .MAX_DEC_DIGITS (MAX_DEC_DIGITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

[hw/rtl/xeu_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_checker
// Port-level checks for the entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
module xeu_checker
   import xeu_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire req_payload_type req_data,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_data
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // end of string always produces a result, so the block stays busy
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.in_end) |=> !req_ready)
      else $error("request taken again right after end of string");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind xml_entity_unescape xeu_checker u_checker (.*);
`default_nettype wire

[test/tb_xml_entity_unescape.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xml_entity_unescape
// Self-checking bench for the XML entity decoder. Escaped text goes in one
// byte per transaction; a behavioral decoder inside the bench builds the
// expected unescaped bytes, and every output transaction is checked against
// the oldest pending one. Directed strings cover the entity kinds and the
// corner cases. Random text follows, mostly entities with random content and
// some noise, under random stalls on both channels and a long output hold.
// ----------------------------------------------------------------------------
module tb_xml_entity_unescape;
   import xeu_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_BYTES   = 5;
   localparam int DEC_DIGITS   = 3;
   localparam int MAX_PER_ITEM = 6;
   localparam int REPORT_LIMIT = 10;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   xml_entity_unescape dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // entity table
   string      ent_text  [5] = '{"quot", "amp", "apos", "lt", "gt"};
   logic [7:0] ent_value [5] = '{8'h22, 8'h26, 8'h27, 8'h3C, 8'h3E};
   string      hex_chars     = "0123456789abcdefABCDEF";

   // decoder state
   parse_mode_type mode     = M_IDLE;
   logic [7:0]     held [HOLD_BYTES];
   int unsigned    held_cnt = 0;
   int unsigned    num_val  = 0;
   int unsigned    dig_cnt  = 0;
   logic [7:0]     decoded_now [$];

   rsp_payload_type expected_text [$];

   int  cycle_count     = 0;
   int  bytes_sent      = 0;
   int  bytes_checked   = 0;
   int  mismatches      = 0;
   int  failures        = 0;
   bit  tx_idle_on      = 1'b1;
   bit  rx_idle_on      = 1'b1;
   int  rx_hold_request = 0;
   int  rx_hold_left    = 0;
   int  rx_stall_left   = 0;

   // ------------------------------------------------------------------
   // decoder
   // ------------------------------------------------------------------
   function automatic void emit_byte(logic [7:0] b);
      if (decoded_now.size() < MAX_PER_ITEM) decoded_now.push_back(b);
   endfunction

   function automatic void close_entity();
      mode     = M_IDLE;
      held_cnt = 0;
      num_val  = 0;
      dig_cnt  = 0;
   endfunction

   function automatic bit hold_byte(logic [7:0] c);
      if (held_cnt >= HOLD_BYTES) return 1'b0;
      held[held_cnt] = c;
      held_cnt++;
      return 1'b1;
   endfunction

   function automatic void copy_held();
      for (int i = 0; i < held_cnt; i++) emit_byte(held[i]);
      close_entity();
   endfunction

   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic bit held_name_is(int idx, int k);
      for (int j = 0; j < k; j++)
         if (held[j + 1] != ent_text[idx][j]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit name_continues(logic [7:0] c);
      int k;
      k = held_cnt - 1;
      for (int i = 0; i < 5; i++)
         if (ent_text[i].len() > k && held_name_is(i, k) && ent_text[i][k] == c)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic int name_found();
      int k;
      k = held_cnt - 1;
      for (int i = 0; i < 5; i++)
         if (ent_text[i].len() == k && held_name_is(i, k)) return i;
      return -1;
   endfunction

   function automatic bit extend_entity(logic [7:0] c);
      int h;
      int idx;
      h = hex_digit(c);
      case (mode)
         M_AMP: begin
            if (c == CHAR_HASH) begin
               mode = M_HASH;
               return hold_byte(c);
            end
            if (name_continues(c)) begin
               mode = M_NAME;
               return hold_byte(c);
            end
            return 1'b0;
         end
         M_NAME: begin
            if (c == CHAR_SEMI) begin
               idx = name_found();
               if (idx < 0) return 1'b0;
               emit_byte(ent_value[idx]);
               close_entity();
               return 1'b1;
            end
            if (name_continues(c)) return hold_byte(c);
            return 1'b0;
         end
         M_HASH: begin
            if (c >= "0" && c <= "9") begin
               num_val = 32'(c - "0");
               dig_cnt = 1;
               mode    = M_DEC;
               return hold_byte(c);
            end
            if (c == CHAR_X) begin
               mode = M_HEXX;
               return hold_byte(c);
            end
            return 1'b0;
         end
         M_DEC: begin
            if (c >= "0" && c <= "9" && dig_cnt < DEC_DIGITS) begin
               num_val = num_val * 10 + 32'(c - "0");
               dig_cnt++;
               return hold_byte(c);
            end
            if (c == CHAR_SEMI) begin
               if (num_val < 256) begin
                  emit_byte(num_val[7:0]);
                  close_entity();
               end else begin
                  copy_held();
                  emit_byte(c);
               end
               return 1'b1;
            end
            return 1'b0;
         end
         M_HEXX: begin
            if (h >= 0) begin
               num_val = h;
               dig_cnt = 1;
               mode    = M_HEXD;
               return hold_byte(c);
            end
            return 1'b0;
         end
         M_HEXD: begin
            if (h >= 0 && dig_cnt < 2) begin
               num_val = num_val * 16 + h;
               dig_cnt++;
               return hold_byte(c);
            end
            if (c == CHAR_SEMI) begin
               emit_byte(num_val[7:0]);
               close_entity();
               return 1'b1;
            end
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void open_or_pass(logic [7:0] c);
      if (c == CHAR_AMP) begin
         close_entity();
         held[0]  = c;
         held_cnt = 1;
         mode     = M_AMP;
      end else begin
         emit_byte(c);
      end
   endfunction

   function automatic void decode_byte(logic [7:0] c, logic last);
      rsp_payload_type r;
      decoded_now.delete();
      if (mode != M_IDLE && held_cnt > 0) begin
         if (!extend_entity(c)) begin
            copy_held();
            open_or_pass(c);
         end
      end else begin
         close_entity();
         open_or_pass(c);
      end
      if (last) copy_held();
      foreach (decoded_now[i]) begin
         r.out_byte = decoded_now[i];
         r.out_end  = last && (i == decoded_now.size() - 1);
         expected_text.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------
   task automatic send_item(input logic [7:0] b, input logic last);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data.in_byte <= b;
      req_data.in_end  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit end_last);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], end_last && (i == s.len() - 1));
   endtask

   task automatic send_fragment();
      logic [7:0] frag [$];
      int         kind;
      int         idx;
      int         ndig;
      logic [7:0] specials [4];
      kind     = $urandom_range(0, 9);
      specials = '{CHAR_AMP, CHAR_HASH, CHAR_SEMI, CHAR_X};
      if (kind <= 2) begin
         idx = $urandom_range(0, 4);
         frag.push_back(CHAR_AMP);
         for (int j = 0; j < ent_text[idx].len(); j++) frag.push_back(ent_text[idx][j]);
         frag.push_back(CHAR_SEMI);
      end else if (kind <= 4) begin
         frag.push_back(CHAR_AMP);
         frag.push_back(CHAR_HASH);
         ndig = $urandom_range(0, 4);
         for (int j = 0; j < ndig; j++) frag.push_back(8'("0" + $urandom_range(0, 9)));
         frag.push_back(CHAR_SEMI);
      end else if (kind <= 6) begin
         frag.push_back(CHAR_AMP);
         frag.push_back(CHAR_HASH);
         frag.push_back(($urandom_range(0, 7) == 0) ? "X" : CHAR_X);
         ndig = $urandom_range(0, 3);
         for (int j = 0; j < ndig; j++) frag.push_back(hex_chars[$urandom_range(0, 21)]);
         frag.push_back(CHAR_SEMI);
      end else begin
         ndig = $urandom_range(1, 6);
         for (int j = 0; j < ndig; j++)
            frag.push_back(($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 3)]
                                                       : 8'($urandom_range(0, 255)));
      end
      // corrupt or truncate some entities
      if (kind <= 6 && $urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 1) == 0)
            frag[$urandom_range(1, frag.size() - 1)] = 8'($urandom_range(0, 255));
         else
            void'(frag.pop_back());
      end
      foreach (frag[i])
         send_item(frag[i], ($urandom_range(0, 15) == 0) ||
                            (i == frag.size() - 1 && $urandom_range(0, 3) == 0));
   endtask

   // ------------------------------------------------------------------
   // receiver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rx_hold_request > 0) begin
         rx_hold_left    = rx_hold_request;
         rx_hold_request = 0;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left--;
         rsp_ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
         rx_stall_left = $urandom_range(1, 7) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input rsp_payload_type want,
                                  input rsp_payload_type got);
      failures++;
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%s: expected byte %02h end %0b, got byte %02h end %0b",
                  what, want.out_byte, want.out_end, got.out_byte, got.out_end);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_text.size() == 0) begin
            report_mismatch("unexpected output", '0, rsp_data);
         end else begin
            want = expected_text.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.out_end !== want.out_end)
               report_mismatch("output mismatch", want, rsp_data);
            bytes_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d outputs pending", expected_text.size());
         $display("xml_entity_unescape regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_directed_entities();
      send_text("&lt;", 1'b0);
      send_text("&#0;", 1'b0);
      send_text("&#xFf;", 1'b0);
   endtask

   task automatic test_special_cases();
      send_text("&#256;", 1'b0);
      send_text("&;", 1'b0);
      send_text("&am", 1'b1);
      send_item(CHAR_AMP, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random_text(input int count);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) send_fragment();
   endtask

   task automatic test_output_backpressure();
      int target;
      tx_idle_on      = 1'b0;
      rx_hold_request = 300;
      target          = bytes_sent + 60;
      while (bytes_sent < target) send_fragment();
      tx_idle_on      = 1'b1;
   endtask

   task automatic test_streaming_no_idle();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      test_random_text(100);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_entities();
      test_special_cases();
      test_random_text(320);
      test_output_backpressure();
      test_streaming_no_idle();
      req_valid <= 1'b0;
      while (expected_text.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      failures += expected_text.size();
      $display("sent %0d source bytes, checked %0d decoded bytes, %0d mismatches",
               bytes_sent, bytes_checked, mismatches);
      $display("named, decimal and hex entities, broken and cut-off entities, stalls");
      if (failures == 0) begin
         $display("xml_entity_unescape regression: pass");
      end else begin
         $display("xml_entity_unescape regression: fail");
      end
      $finish;
   end

endmodule
